[rtl/vfdg_pkg.sv]
// Shared types, constants, microcode table and dot helpers for the VFD grid frame formatter.
package vfdg_pkg;

    localparam int BITMAP_BYTES = 39;
    localparam int FRAME_BYTES  = 36;
    localparam int DOT_BITS     = 234;
    localparam int GRID_MAX     = 53;

    localparam int ADDR_W     = 6;
    localparam int GROUP_W    = 4;
    localparam int BYTE_NUM_W = 6;
    localparam int GRID_W     = 6;
    localparam int POS_W      = 9;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    // Phase of an output byte within its three-byte group (24 frame bits, four bitmap bytes)
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    typedef enum logic [1:0] {
        STEP_FETCH,
        STEP_PRIME,
        STEP_STREAM
    } step_t;

    typedef enum logic [1:0] {
        JMP_ON_EMIT,
        JMP_ALWAYS,
        JMP_ON_END
    } jmp_t;

    typedef struct packed {
        logic  take_req;
        logic  issue_rd;
        logic  stream;
        jmp_t  jmp;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
    } store_ctrl_t;

    typedef struct packed {
        logic                  load;
        logic [1:0]            phase;
        logic [GRID_W-1:0]     grid;
        logic [BYTE_NUM_W-1:0] byte_number;
        logic                  last;
    } fmt_ctrl_t;

    // Control program: one word per step
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t word;
        word = '{take_req: 1'b1, issue_rd: 1'b0, stream: 1'b0,
                 jmp: JMP_ON_EMIT, target: STEP_PRIME};
        case (step)
            STEP_FETCH:  word = '{take_req: 1'b1, issue_rd: 1'b0, stream: 1'b0,
                                  jmp: JMP_ON_EMIT, target: STEP_PRIME};
            STEP_PRIME:  word = '{take_req: 1'b0, issue_rd: 1'b1, stream: 1'b0,
                                  jmp: JMP_ALWAYS, target: STEP_STREAM};
            STEP_STREAM: word = '{take_req: 1'b0, issue_rd: 1'b0, stream: 1'b1,
                                  jmp: JMP_ON_END, target: STEP_FETCH};
            default:     word = '{take_req: 1'b1, issue_rd: 1'b0, stream: 1'b0,
                                  jmp: JMP_ON_EMIT, target: STEP_PRIME};
        endcase
        return word;
    endfunction

    // Six frame dot fields of one bitmap byte, bit p for dot position p
    function automatic logic [5:0] dots6(logic [7:0] b, logic odd);
        logic [5:0] d;
        d = '0;
        if (odd)
        begin
            d[0] = b[7];
            d[2] = b[6];
            d[4] = b[5];
        end
        else
        begin
            d[1] = b[2];
            d[3] = b[3];
            d[5] = b[4];
        end
        return d;
    endfunction

endpackage

[rtl/vfdg_if.sv]
// Request channel interfaces for the VFD grid frame formatter.
interface vfdg_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [5:0] byte_index;
    logic [7:0] pixel_byte;
    logic [5:0] grid;

    modport source (output valid, mode, byte_index, pixel_byte, grid, input ready);
    modport sink   (input valid, mode, byte_index, pixel_byte, grid, output ready);
endinterface

interface vfdg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_number;
    logic       last;

    modport source (output valid, frame_byte, byte_number, last, input ready);
    modport sink   (input valid, frame_byte, byte_number, last, output ready);
endinterface

[rtl/vfdg_store.sv]
// Bitmap store: 39-byte memory with per-entry valid bits and two registered read ports.
module vfdg_store
    import vfdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_ctrl_t st_ctrl,
    output logic [7:0]  rd0,
    output logic [7:0]  rd1
);

    logic [7:0]             store_mem [BITMAP_BYTES];
    logic [BITMAP_BYTES-1:0] valid_reg;
    logic [7:0]             rd0_reg;
    logic [7:0]             rd1_reg;
    logic                   wr_ok;
    logic                   rd0_ok;
    logic                   rd1_ok;

    // Drop writes and reads beyond the store; unwritten entries read as zero
    assign wr_ok  = st_ctrl.wr_en && (st_ctrl.wr_addr < ADDR_W'(BITMAP_BYTES));
    assign rd0_ok = (st_ctrl.rd_addr0 < ADDR_W'(BITMAP_BYTES)) && valid_reg[st_ctrl.rd_addr0];
    assign rd1_ok = (st_ctrl.rd_addr1 < ADDR_W'(BITMAP_BYTES)) && valid_reg[st_ctrl.rd_addr1];

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_ok)
            valid_reg[st_ctrl.wr_addr] <= 1'b1;
    end

    // Write port and read ports; hold read data between issues
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            store_mem[st_ctrl.wr_addr] <= st_ctrl.wr_data;
        if (st_ctrl.rd_en)
        begin
            rd0_reg <= rd0_ok ? store_mem[st_ctrl.rd_addr0] : 8'h00;
            rd1_reg <= rd1_ok ? store_mem[st_ctrl.rd_addr1] : 8'h00;
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

`ifndef NO_ASSERTIONS
    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (st_ctrl.wr_en && st_ctrl.wr_addr >= ADDR_W'(BITMAP_BYTES)) |=> $stable(valid_reg))
        else $error("write beyond the store changed a valid bit");
`endif

endmodule

[rtl/vfdg_formatter.sv]
// Frame byte assembly from two bitmap bytes, grid-select bits, and the output register.
module vfdg_formatter
    import vfdg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fmt_ctrl_t  fm_ctrl,
    input  logic [7:0] rd0,
    input  logic [7:0] rd1,
    output logic       out_free,
    vfdg_out_if.source result
);

    logic                  valid_reg;
    logic [7:0]            frame_byte_reg;
    logic [BYTE_NUM_W-1:0] byte_number_reg;
    logic                  last_reg;
    logic [5:0]            lo_dots;
    logic [5:0]            hi_dots;
    logic [7:0]            dot_byte;
    logic [7:0]            sel_byte;
    logic                  grid_ok;
    logic [POS_W-1:0]      sel_base;
    logic [POS_W-1:0]      byte_base;

    assign out_free = !valid_reg || result.ready;

    // Pick the dot fields of this byte from the two bitmap bytes
    always_comb
    begin
        lo_dots = dots6(rd0, fm_ctrl.grid[0]);
        hi_dots = dots6(rd1, fm_ctrl.grid[0]);
        case (fm_ctrl.phase)
            PHASE_0: dot_byte = {hi_dots[1:0], lo_dots};
            PHASE_1: dot_byte = {hi_dots[3:0], lo_dots[5:2]};
            PHASE_2: dot_byte = {hi_dots, lo_dots[5:4]};
            default: dot_byte = 8'h00;
        endcase
    end

    // Set the two grid-select bits that fall in this byte
    always_comb
    begin
        grid_ok   = (fm_ctrl.grid >= GRID_W'(1)) && (fm_ctrl.grid <= GRID_W'(GRID_MAX));
        sel_base  = POS_W'(fm_ctrl.grid) + POS_W'(DOT_BITS - 1);
        byte_base = {fm_ctrl.byte_number, 3'b000};
        for (int i = 0; i < 8; i++)
        begin
            sel_byte[i] = grid_ok &&
                ((byte_base + POS_W'(i) == sel_base) ||
                 (byte_base + POS_W'(i) == sel_base + POS_W'(1)));
        end
    end

    // Hold the request until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (fm_ctrl.load)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fm_ctrl.load)
        begin
            frame_byte_reg  <= dot_byte | sel_byte;
            byte_number_reg <= fm_ctrl.byte_number;
            last_reg        <= fm_ctrl.last;
        end
    end

    assign result.valid       = valid_reg;
    assign result.frame_byte  = frame_byte_reg;
    assign result.byte_number = byte_number_reg;
    assign result.last        = last_reg;

endmodule

[rtl/vfdg_sequencer.sv]
// Microcoded sequencer: step counter over the control table, byte counters and store addressing.
module vfdg_sequencer
    import vfdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vfdg_in_if.sink     item,
    input  logic        out_free,
    output store_ctrl_t st_ctrl,
    output fmt_ctrl_t   fm_ctrl
);

    step_t                 step_reg;
    step_t                 step_next;
    logic [BYTE_NUM_W-1:0] byte_cnt_reg;
    logic [BYTE_NUM_W-1:0] byte_cnt_next;
    logic [GROUP_W-1:0]    rd_grp_reg;
    logic [GROUP_W-1:0]    rd_grp_next;
    logic [1:0]            rd_phase_reg;
    logic [1:0]            rd_phase_next;
    logic [1:0]            fmt_phase_reg;
    logic [GRID_W-1:0]     grid_reg;
    ucode_t                word;
    logic                  accept;
    logic                  emit_acc;
    logic                  load_acc;
    logic                  fire;
    logic                  issue;
    logic                  last_byte;
    logic [ADDR_W-1:0]     rd_addr0;

    // Decode the current control word
    always_comb
    begin
        word      = ucode_rom(step_reg);
        accept    = item.valid && word.take_req;
        emit_acc  = accept && (item.mode == MODE_EMIT);
        load_acc  = accept && (item.mode == MODE_LOAD);
        fire      = word.stream && out_free;
        issue     = word.issue_rd || fire;
        last_byte = byte_cnt_reg == BYTE_NUM_W'(FRAME_BYTES - 1);
    end

    assign item.ready = word.take_req;

    // Advance the step counter
    always_comb
    begin
        step_next = step_reg;
        case (word.jmp)
            JMP_ON_EMIT: if (emit_acc) step_next = word.target;
            JMP_ALWAYS:  step_next = word.target;
            JMP_ON_END:  if (fire && last_byte) step_next = word.target;
            default:     step_next = step_reg;
        endcase
    end

    // Advance the read pointer and the output byte counter
    always_comb
    begin
        rd_grp_next   = rd_grp_reg;
        rd_phase_next = rd_phase_reg;
        byte_cnt_next = byte_cnt_reg;
        if (emit_acc)
        begin
            rd_grp_next   = '0;
            rd_phase_next = PHASE_0;
            byte_cnt_next = '0;
        end
        else
        begin
            if (issue)
            begin
                if (rd_phase_reg == PHASE_2)
                begin
                    rd_phase_next = PHASE_0;
                    rd_grp_next   = rd_grp_reg + GROUP_W'(1);
                end
                else
                    rd_phase_next = rd_phase_reg + 2'd1;
            end
            if (fire)
                byte_cnt_next = last_byte ? '0 : byte_cnt_reg + BYTE_NUM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_FETCH;
            byte_cnt_reg <= '0;
            rd_grp_reg   <= '0;
            rd_phase_reg <= PHASE_0;
        end
        else
        begin
            step_reg     <= step_next;
            byte_cnt_reg <= byte_cnt_next;
            rd_grp_reg   <= rd_grp_next;
            rd_phase_reg <= rd_phase_next;
        end
    end

    // Latch the grid and track the phase of the data held in the read registers
    always_ff @(posedge clk)
    begin
        if (emit_acc)
            grid_reg <= item.grid;
        if (issue)
            fmt_phase_reg <= rd_phase_reg;
    end

    // First bitmap byte of a group phase: 4 per group, offset by phase
    assign rd_addr0 = {rd_grp_reg, 2'b00} + ADDR_W'(rd_phase_reg);

    always_comb
    begin
        st_ctrl.wr_en    = load_acc;
        st_ctrl.wr_addr  = item.byte_index;
        st_ctrl.wr_data  = item.pixel_byte;
        st_ctrl.rd_en    = issue;
        st_ctrl.rd_addr0 = rd_addr0;
        st_ctrl.rd_addr1 = rd_addr0 + ADDR_W'(1);

        fm_ctrl.load        = fire;
        fm_ctrl.phase       = fmt_phase_reg;
        fm_ctrl.grid        = grid_reg;
        fm_ctrl.byte_number = byte_cnt_reg;
        fm_ctrl.last        = last_byte;
    end

`ifndef NO_ASSERTIONS
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_FETCH) |-> (byte_cnt_reg == '0))
        else $error("byte counter not cleared while idle");

    a_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> (step_reg == STEP_FETCH))
        else $error("sequencer did not return to fetch after the final byte");

    a_emit_primes: assert property (@(posedge clk) disable iff (!rst_n)
        emit_acc |=> (step_reg == STEP_PRIME && rd_grp_reg == '0 && rd_phase_reg == PHASE_0))
        else $error("emit request did not restart the read pointer");

    a_no_fire_outside_stream: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (step_reg == STEP_STREAM && !item.ready))
        else $error("output loaded outside the stream step");
`endif

endmodule

[rtl/vfd_grid_frame_formatter_top.sv]
// A load request is taken at once in the fetch step; the next request is taken in the following cycle.
// After acceptance an emit request passes the read priming step, which fills the store's read
// registers, and then the output register; then one frame byte per cycle follows from the
// two-port bitmap store read while the sink does not stall, 36 bytes in all; no request is taken meanwhile.
// Reset clears the sequencer and the store's valid bits at once: every bitmap byte reads zero.
// Top level of the VFD grid frame formatter.
module vfd_grid_frame_formatter_top
    import vfdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vfdg_in_if.sink     item,
    vfdg_out_if.source  result
);

    store_ctrl_t st_ctrl;
    fmt_ctrl_t   fm_ctrl;
    logic [7:0]  rd0;
    logic [7:0]  rd1;
    logic        out_free;

    vfdg_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .out_free (out_free),
        .st_ctrl  (st_ctrl),
        .fm_ctrl  (fm_ctrl)
    );

    vfdg_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .st_ctrl (st_ctrl),
        .rd0     (rd0),
        .rd1     (rd1)
    );

    vfdg_formatter u_fmt (
        .clk      (clk),
        .rst_n    (rst_n),
        .fm_ctrl  (fm_ctrl),
        .rd0      (rd0),
        .rd1      (rd1),
        .out_free (out_free),
        .result   (result)
    );

endmodule

[tb/sv/vfdg_frame_checker.sv]
`timescale 1ns / 1ps
// Checker for the VFD grid frame formatter: watches both channels, predicts frame bytes and compares.
module vfdg_frame_checker
    import vfdg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vfdg_in_if   item,
    vfdg_out_if  result,
    output int   mismatches,
    output int   outstanding
);

    localparam int DOTS_PER_BYTE = 6;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0]            frame_byte;
        logic [BYTE_NUM_W-1:0] byte_number;
        logic                  last;
    } frame_byte_t;

    logic [7:0]  bitmap_shadow [BITMAP_BYTES];
    frame_byte_t frame_bytes_due [$];
    int          bad_count = 0;

    // Build the whole 288-bit frame for a grid from the shadow bitmap
    function automatic logic [FRAME_BYTES*8-1:0] grid_frame_bits(input logic [GRID_W-1:0] grid_no);
        logic [FRAME_BYTES*8-1:0] frame;
        logic [7:0]               src;
        int                       k;
        int                       p;
        frame = '0;
        for (k = 0; k < DOT_BITS; k++)
        begin
            src = bitmap_shadow[k / DOTS_PER_BYTE];
            p   = k % DOTS_PER_BYTE;
            // odd grids drive dots a to c on even positions, even grids d to f on odd ones
            if (grid_no[0] && (p % 2 == 0))
                frame[k] = src[7 - p / 2];
            else if (!grid_no[0] && (p % 2 == 1))
                frame[k] = src[2 + (p - 1) / 2];
        end
        // set the two grid-select bits only for a grid in range
        if (grid_no >= 1 && grid_no <= GRID_MAX)
        begin
            frame[DOT_BITS - 1 + grid_no] = 1'b1;
            frame[DOT_BITS + grid_no]     = 1'b1;
        end
        return frame;
    endfunction

    task automatic note_mismatch(input string what, input frame_byte_t want, input frame_byte_t got);
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
            $display("%0t %s: expected byte %h number %0d last %b, got byte %h number %0d last %b",
                     $realtime, what, want.frame_byte, want.byte_number, want.last,
                     got.frame_byte, got.byte_number, got.last);
    endtask

    always @(posedge clk)
    begin
        frame_byte_t              got;
        frame_byte_t              want;
        logic [FRAME_BYTES*8-1:0] frame;
        if (!rst_n)
        begin
            // Clear the shadow bitmap and drop anything queued
            foreach (bitmap_shadow[i])
                bitmap_shadow[i] = 8'h00;
            frame_bytes_due.delete();
        end
        else
        begin
            // Compare each accepted frame byte with the oldest one due
            if (result.valid && result.ready)
            begin
                got = '{frame_byte: result.frame_byte, byte_number: result.byte_number,
                        last: result.last};
                if (frame_bytes_due.size() == 0)
                    note_mismatch("unexpected frame byte", '0, got);
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (got.frame_byte !== want.frame_byte)
                        note_mismatch("frame_byte differs", want, got);
                    else if (got.byte_number !== want.byte_number)
                        note_mismatch("byte_number differs", want, got);
                    else if (got.last !== want.last)
                        note_mismatch("last differs", want, got);
                end
            end

            // Update the shadow bitmap on a load, queue a full frame on an emit
            if (item.valid && item.ready)
            begin
                if (item.mode == MODE_LOAD)
                begin
                    if (item.byte_index < BITMAP_BYTES)
                        bitmap_shadow[item.byte_index] = item.pixel_byte;
                end
                else
                begin
                    frame = grid_frame_bits(item.grid);
                    for (int j = 0; j < FRAME_BYTES; j++)
                    begin
                        want.frame_byte  = frame[8*j +: 8];
                        want.byte_number = j[BYTE_NUM_W-1:0];
                        want.last        = (j == FRAME_BYTES - 1);
                        frame_bytes_due.push_back(want);
                    end
                end
            end
        end
        mismatches  <= bad_count;
        outstanding <= frame_bytes_due.size();
    end

endmodule

[tb/sv/tb_vfd_grid_frame_formatter_top.sv]
`timescale 1ns / 1ps
// Testbench top for the VFD grid frame formatter: clock, reset, request stimulus and verdict.
module tb_vfd_grid_frame_formatter_top;
    import vfdg_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   cycle_count   = 0;
    int   mismatches;
    int   outstanding;
    int   calm_requests = 0;
    int   ready_hold    = 0;
    int   ready_calm    = 0;
    int   ready_roll;

    vfdg_in_if  item ();
    vfdg_out_if result ();

    vfd_grid_frame_formatter_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    vfdg_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the result side: short and long holds, with calm stretches in between
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (ready_calm > 0)
        begin
            ready_calm   <= ready_calm - 1;
            result.ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold   <= ready_hold - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 3)
            begin
                ready_calm   <= $urandom_range(40, 150);
                result.ready <= 1'b1;
            end
            else if (ready_roll < 30)
            begin
                ready_hold   <= $urandom_range(0, 2);
                result.ready <= 1'b0;
            end
            else if (ready_roll < 33)
            begin
                ready_hold   <= $urandom_range(10, 40);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] index,
                                input logic [7:0] pixel, input logic [GRID_W-1:0] grid_no);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_requests > 0)
        begin
            calm_requests--;
            gap = 0;
        end
        else if (roll < 4)
        begin
            calm_requests = $urandom_range(15, 50);
            gap = 0;
        end
        else if (roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);

        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid      <= 1'b1;
        item.mode       <= mode;
        item.byte_index <= index;
        item.pixel_byte <= pixel;
        item.grid       <= grid_no;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every queued frame byte has arrived
    task automatic wait_for_frames();
        item.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               random_sent;
        int               burst;
        int               roll;
        logic [GRID_W-1:0] grid_no;

        item.valid      <= 1'b0;
        item.mode       <= MODE_LOAD;
        item.byte_index <= '0;
        item.pixel_byte <= '0;
        item.grid       <= '0;
        rst_n           <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extreme bytes, spare bits, ignored loads, edge grids
        send_request(MODE_EMIT, 6'd63, 8'hFF, 6'd1);
        send_request(MODE_LOAD, 6'd0, 8'hFF, 6'd63);
        send_request(MODE_LOAD, 6'd38, 8'hFF, 6'd0);
        send_request(MODE_LOAD, 6'd1, 8'hFC, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd2, 8'h03, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd37, 8'hA8, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd36, 8'h54, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd5, 8'hFF, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd5, 8'h00, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd39, 8'h55, GRID_W'($urandom));
        send_request(MODE_LOAD, 6'd63, 8'hFF, GRID_W'($urandom));
        send_request(MODE_EMIT, 6'd0, 8'h00, 6'd1);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd2);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd53);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd52);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd0);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd54);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd63);
        send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), 6'd32);
        wait_for_frames();

        // Random: bursts of loads followed by an emit, with some out-of-range noise
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(0, 8);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 90)
                begin
                    send_request(MODE_LOAD, ADDR_W'($urandom_range(0, BITMAP_BYTES - 1)),
                                 8'($urandom), GRID_W'($urandom));
                    random_sent++;
                end
                else
                    send_request(MODE_LOAD, ADDR_W'($urandom_range(BITMAP_BYTES, 63)),
                                 8'($urandom), GRID_W'($urandom));
            end

            roll = $urandom_range(0, 99);
            if (roll < 90)
                grid_no = GRID_W'($urandom_range(1, GRID_MAX));
            else if (roll < 94)
                grid_no = '0;
            else
                grid_no = GRID_W'($urandom_range(GRID_MAX + 1, 63));
            send_request(MODE_EMIT, ADDR_W'($urandom), 8'($urandom), grid_no);
            random_sent++;

            if ($urandom_range(0, 15) == 0)
                wait_for_frames();
        end

        wait_for_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
